/* hw/rtl/hsv2rgb_pkg.sv */
// hsv2rgb_pkg: constants and the color packing function for the HSV to RGB converter.
// Depends on nothing. Used by hsv_to_rgb_converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Input and output widths
  localparam int HUE_W   = 9;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 24;

  // Hue clamp and degree to 0..255 scaling: (hue*32)/45 == (hue*HUE_RECIP) >> HUE_SHIFT
  localparam logic [HUE_W-1:0] HUE_MAX_DEG = 9'd359;
  localparam logic [13:0]      HUE_RECIP   = 14'd11651;
  localparam int               HUE_PROD_W  = HUE_W + 14;
  localparam int               HUE_SHIFT   = 14;

  // Sextant width on the scaled hue
  localparam logic [7:0] SEXT_SPAN = 8'd43;

  // Sextant codes
  localparam logic [2:0] SEXT_RED_YEL = 3'd0;
  localparam logic [2:0] SEXT_YEL_GRN = 3'd1;
  localparam logic [2:0] SEXT_GRN_CYN = 3'd2;
  localparam logic [2:0] SEXT_CYN_BLU = 3'd3;
  localparam logic [2:0] SEXT_BLU_MAG = 3'd4;
  localparam logic [2:0] SEXT_MAG_RED = 3'd5;

  // Pack modes
  localparam logic PACK_RGB888 = 1'b0;
  localparam logic PACK_RGB565 = 1'b1;

  // Pack three channels as RGB888 or RGB565 (low 16 bits)
  function automatic logic [COLOR_W-1:0] pack_color(input logic mode,
                                                    input logic [CHAN_W-1:0] r,
                                                    input logic [CHAN_W-1:0] g,
                                                    input logic [CHAN_W-1:0] b);
    logic [COLOR_W-1:0] res;
    if (mode == PACK_RGB565) begin
      res = {8'd0, r[7:3], g[7:2], b[7:3]};
    end else begin
      res = {r, g, b};
    end
    return res;
  endfunction

endpackage

/* hw/rtl/hsv_to_rgb_converter.sv */
// hsv_to_rgb_converter: five-stage pipelined HSV to RGB888/RGB565 converter.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

// Usage
//   Input: a request is taken at a rising edge with start high and busy low.
//   busy is always low, so one pixel (in_hue_deg, in_saturation,
//   in_brightness) can be taken every cycle. Hue above 359 is treated as 359.
//   Output: out_valid strobes for one cycle with out_color; the receiver
//   cannot stall, so nothing is ever held back.
//   Pipeline: a request taken at an edge passes five register stages (hue
//   scale multiply, sextant split plus p multiply, s*r products, q/t
//   multiplies, select and pack) before it reaches the outputs. Throughput
//   is one pixel per clock, set by the fully pipelined multipliers.
//   Configuration: cfg_pack_565 is written when cfg_valid is high; cfg_ready
//   is always high. 0 packs R<<16|G<<8|B, 1 packs RGB565 in the low 16 bits.
//   Write it only while no pixel is in flight.
//   Reset (rst_n low, synchronous) clears all valid bits and selects RGB888.
module hsv_to_rgb_converter (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel requests
  input  logic                               start,
  output logic                               busy,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]      in_hue_deg,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]     in_saturation,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]     in_brightness,
  // results
  output logic                               out_valid,
  output logic [hsv2rgb_pkg::COLOR_W-1:0]    out_color,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_pack_565
);

  localparam int CW = hsv2rgb_pkg::CHAN_W;

  // Pack mode register
  logic pack_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_r <= hsv2rgb_pkg::PACK_RGB888;
    end else if (cfg_valid && cfg_ready) begin
      pack_r <= cfg_pack_565;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 1: clamp hue and scale to 0..255 by reciprocal multiply
  // ---------------------------------------------------------------------
  logic                                   v1_r;
  logic [CW-1:0]                          h8_r, s1_r, b1_r;
  logic [hsv2rgb_pkg::HUE_W-1:0]          hue_clamp;
  logic [hsv2rgb_pkg::HUE_PROD_W-1:0]     hue_prod;
  logic [CW-1:0]                          h8_nxt;

  always_comb begin
    hue_clamp = (in_hue_deg > hsv2rgb_pkg::HUE_MAX_DEG) ? hsv2rgb_pkg::HUE_MAX_DEG
                                                        : in_hue_deg;
    hue_prod  = {14'd0, hue_clamp} * {9'd0, hsv2rgb_pkg::HUE_RECIP};
    h8_nxt    = hue_prod[hsv2rgb_pkg::HUE_SHIFT +: CW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    h8_r <= h8_nxt;
    s1_r <= in_saturation;
    b1_r <= in_brightness;
  end

  // ---------------------------------------------------------------------
  // Stage 2: sextant and remainder*6 by compares; p = v*(255-s) >> 8
  // ---------------------------------------------------------------------
  logic          v2_r;
  logic [2:0]    sext2_r, sext_nxt;
  logic [CW-1:0] rem2_r, rem_nxt, p2_r, s2_r, b2_r;
  logic [CW-1:0] base;
  logic [5:0]    diff;
  logic [15:0]   p_prod;

  always_comb begin
    if (h8_r >= 8'd215) begin
      sext_nxt = hsv2rgb_pkg::SEXT_MAG_RED;
    end else if (h8_r >= 8'd172) begin
      sext_nxt = hsv2rgb_pkg::SEXT_BLU_MAG;
    end else if (h8_r >= 8'd129) begin
      sext_nxt = hsv2rgb_pkg::SEXT_CYN_BLU;
    end else if (h8_r >= 8'd86) begin
      sext_nxt = hsv2rgb_pkg::SEXT_GRN_CYN;
    end else if (h8_r >= hsv2rgb_pkg::SEXT_SPAN) begin
      sext_nxt = hsv2rgb_pkg::SEXT_YEL_GRN;
    end else begin
      sext_nxt = hsv2rgb_pkg::SEXT_RED_YEL;
    end
    // sextant start on the scaled hue
    base    = 8'(sext_nxt * hsv2rgb_pkg::SEXT_SPAN);
    diff    = 6'(h8_r - base);
    rem_nxt = {diff, 2'b00} + {1'b0, diff, 1'b0};
    p_prod  = {8'd0, b1_r} * {8'd0, 8'hFF - s1_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    sext2_r <= sext_nxt;
    rem2_r  <= rem_nxt;
    p2_r    <= p_prod[15:8];
    s2_r    <= s1_r;
    b2_r    <= b1_r;
  end

  // ---------------------------------------------------------------------
  // Stage 3: complemented s*r and s*(255-r)
  // ---------------------------------------------------------------------
  logic          v3_r;
  logic [2:0]    sext3_r;
  logic [CW-1:0] p3_r, b3_r;
  logic          grey3_r;
  logic [15:0]   qa3_r, ta3_r, qa_nxt, ta_nxt;

  always_comb begin
    qa_nxt = 16'hFFFF - ({8'd0, s2_r} * {8'd0, rem2_r});
    ta_nxt = 16'hFFFF - ({8'd0, s2_r} * {8'd0, 8'hFF - rem2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    sext3_r <= sext2_r;
    p3_r    <= p2_r;
    b3_r    <= b2_r;
    grey3_r <= (s2_r == '0);
    qa3_r   <= qa_nxt;
    ta3_r   <= ta_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 4: q = v*qa >> 16, t = v*ta >> 16
  // ---------------------------------------------------------------------
  logic          v4_r;
  logic [2:0]    sext4_r;
  logic [CW-1:0] p4_r, q4_r, t4_r, b4_r;
  logic          grey4_r;
  logic [23:0]   q_prod, t_prod;

  always_comb begin
    q_prod = {16'd0, b3_r} * {8'd0, qa3_r};
    t_prod = {16'd0, b3_r} * {8'd0, ta3_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    sext4_r <= sext3_r;
    p4_r    <= p3_r;
    q4_r    <= q_prod[23:16];
    t4_r    <= t_prod[23:16];
    b4_r    <= b3_r;
    grey4_r <= grey3_r;
  end

  // ---------------------------------------------------------------------
  // Stage 5: channel order by sextant, grey override, pack
  // ---------------------------------------------------------------------
  logic                                out_valid_r;
  logic                                out_pack_r;
  logic [hsv2rgb_pkg::COLOR_W-1:0]     color_r, color_nxt;
  logic [CW-1:0]                       ch_red, ch_grn, ch_blu;

  always_comb begin
    case (sext4_r)
      hsv2rgb_pkg::SEXT_RED_YEL: begin ch_red = b4_r; ch_grn = t4_r; ch_blu = p4_r; end
      hsv2rgb_pkg::SEXT_YEL_GRN: begin ch_red = q4_r; ch_grn = b4_r; ch_blu = p4_r; end
      hsv2rgb_pkg::SEXT_GRN_CYN: begin ch_red = p4_r; ch_grn = b4_r; ch_blu = t4_r; end
      hsv2rgb_pkg::SEXT_CYN_BLU: begin ch_red = p4_r; ch_grn = q4_r; ch_blu = b4_r; end
      hsv2rgb_pkg::SEXT_BLU_MAG: begin ch_red = t4_r; ch_grn = p4_r; ch_blu = b4_r; end
      default:                   begin ch_red = b4_r; ch_grn = p4_r; ch_blu = q4_r; end
    endcase
    // zero saturation: grey at the value level
    if (grey4_r) begin
      ch_red = b4_r;
      ch_grn = b4_r;
      ch_blu = b4_r;
    end
    color_nxt = hsv2rgb_pkg::pack_color(pack_r, ch_red, ch_grn, ch_blu);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v4_r;
    end
    color_r    <= color_nxt;
    out_pack_r <= pack_r;
  end

  assign out_valid = out_valid_r;
  assign out_color = color_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // every request comes out of the pipeline as a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("request did not produce a result after five cycles");

  // no result appears without a matching earlier request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without a matching request");

  // RGB565 results keep the upper byte clear
  a_565_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pack_r == hsv2rgb_pkg::PACK_RGB565) |-> (out_color[23:16] == 8'd0))
    else $error("RGB565 result has nonzero upper byte");

  // reset leaves the output strobe low
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe high right after reset");

endmodule
